>>> rtl/b32e_pkg.sv
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types, constants and the symbol-to-character map of the Base32
// stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b32e_pkg;

  localparam int unsigned GROUP_CHARS = 8;
  localparam int unsigned MAX_SYMS    = 3;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_TWO     = 8'h32;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;
  localparam logic [4:0] SYM_LETTERS  = 5'd26;

  typedef logic [4:0] sym_t;

  // One classified request: data symbols first, then padding characters.
  typedef struct packed {
    sym_t [MAX_SYMS-1:0] sym;
    logic [1:0]          nsym;
    logic [3:0]          npad;
  } job_t;

  function automatic logic [7:0] b32_char(input sym_t v);
    logic [7:0] ch;
    if (v < SYM_LETTERS) begin
      ch = CHAR_UPPER_A + {3'd0, v};
    end else begin
      ch = CHAR_TWO + {3'd0, v - SYM_LETTERS};
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> rtl/base32_stream_encoder.sv
// ----------------------------------------------------------------------------
// base32_stream_encoder
// Base32 encoder for a byte stream: five bits to a character, flush and
// '=' padding to a whole group of eight on the last byte.
//
//   Channel | Dir | tdata            | tlast
//   in_     | in  | [7:0] data_byte  | last_byte
//   out_    | out | [7:0] out_char   | end_of_run
//
// One character leaves per cycle unless the output stalls or the queue is
// empty; a byte yields 1 to 8 characters.
// A byte is taken whenever the two-entry request queue has room.
// Synchronous active-low reset clears leftover bits, group position,
// queue, walker position and output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module base32_stream_encoder
  import b32e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_char
  output logic            out_tlast
);

  logic q_full;
  logic q_push;
  job_t q_job;
  logic q_pop;
  logic q_valid;
  job_t q_head;

  b32e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  b32e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  b32e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/b32e_front.sv
// ----------------------------------------------------------------------------
// b32e_front
// Accepts input bytes, joins them with leftover bits and classifies each
// request into data symbols, a flush symbol and a padding count.
// ----------------------------------------------------------------------------
`default_nettype none

module b32e_front
  import b32e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       q_full,
  output logic            q_push,
  output job_t            q_job
);

  logic [3:0] pend_bits_r, pend_bits_nxt;
  logic [2:0] pend_cnt_r,  pend_cnt_nxt;
  logic [2:0] grp_pos_r,   grp_pos_nxt;

  logic [2:0]  cnt;
  logic [3:0]  pmask;
  logic [11:0] acc;
  logic [3:0]  nbits;
  logic        two;
  logic [3:0]  rem;
  logic [3:0]  sh0;
  logic [3:0]  rmask;
  logic [3:0]  remv;
  sym_t        sym0, sym1, flush;
  logic [1:0]  k;
  logic [2:0]  gpos;
  logic [3:0]  pads;
  logic [3:0]  room;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    cnt   = (pend_cnt_r > 3'd4) ? 3'd4 : pend_cnt_r;
    pmask = 4'((5'd1 << cnt) - 5'd1);
    acc   = {pend_bits_r & pmask, in_tdata};
    nbits = {1'b0, cnt} + 4'd8;
    two   = (nbits >= 4'd10);
    sh0   = nbits - 4'd5;
    rem   = two ? (nbits - 4'd10) : sh0;
    sym0  = 5'(acc >> sh0);
    sym1  = 5'(acc >> rem);
    rmask = 4'((5'd1 << rem) - 5'd1);
    remv  = acc[3:0] & rmask;
    flush = 5'({1'b0, remv} << (3'd5 - rem[2:0]));

    q_job      = '0;
    q_job.sym[0] = sym0;
    k          = two ? 2'd2 : 2'd1;
    if (two) begin
      q_job.sym[1] = sym1;
    end
    if (in_tlast && rem != 4'd0) begin
      if (two) begin
        q_job.sym[2] = flush;
      end else begin
        q_job.sym[1] = flush;
      end
      k = k + 2'd1;
    end
    q_job.nsym = k;

    gpos = grp_pos_r + {1'b0, k};
    room = 4'(GROUP_CHARS) - {2'd0, k};
    pads = {1'b0, 3'd0 - gpos};
    if (!in_tlast) begin
      pads = 4'd0;
    end else if (pads > room) begin
      pads = room;
    end
    q_job.npad = pads;

    if (in_tlast) begin
      pend_bits_nxt = 4'd0;
      pend_cnt_nxt  = 3'd0;
      grp_pos_nxt   = 3'd0;
    end else begin
      pend_bits_nxt = remv;
      pend_cnt_nxt  = rem[2:0];
      grp_pos_nxt   = gpos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= 4'd0;
      pend_cnt_r  <= 3'd0;
      grp_pos_r   <= 3'd0;
    end else if (q_push) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      grp_pos_r   <= grp_pos_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/b32e_queue.sv
// ----------------------------------------------------------------------------
// b32e_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module b32e_queue
  import b32e_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output job_t      head
);

  job_t       mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = pop ? ~rptr_r : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/b32e_back.sv
// ----------------------------------------------------------------------------
// b32e_back
// Walks each queued request, one character per cycle while the output is
// free, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b32e_back
  import b32e_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  job_t      q_head,
  output logic      q_pop,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic [3:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;

  logic       load;
  logic [3:0] total;
  logic       at_end;

  assign out_tvalid = vld_r;
  assign out_tdata  = char_r;
  assign out_tlast  = last_r;

  always_comb begin
    load   = q_valid && (!vld_r || out_tready);
    total  = {2'd0, q_head.nsym} + q_head.npad;
    at_end = (idx_r == total - 4'd1);
    q_pop  = load && at_end;

    if (idx_r < {2'd0, q_head.nsym}) begin
      char_nxt = b32_char(q_head.sym[idx_r[1:0]]);
    end else begin
      char_nxt = CHAR_PAD;
    end
    last_nxt = at_end;

    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = at_end ? 4'd0 : idx_r + 4'd1;
    end

    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= char_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 4'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base32_stream_encoder. Byte messages go in,
// starting with known strings and edge bytes that give every padding
// length. Random messages of random length follow. A scoreboard predicts
// each character and its end-of-run flag from the bytes taken. Both sides
// stall at random, with one calm stretch and one long output hold-off that
// backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import b32e_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RESET_TICKS = 9;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_TICKS  = 150;
  localparam int DRAIN_TICKS = 20;
  localparam int RAND_BYTES  = 160;
  localparam int SHOWN_ERRS  = 10;

  typedef struct {
    logic [7:0] ch;
    logic       eor;
  } b32_char_t;

  class char_scoreboard;
    b32_char_t  expected_chars[$];
    logic [3:0] pend_bits;
    logic [2:0] pend_cnt;
    logic [2:0] grp_pos;
    int         mismatches;
    int         checked;

    function new();
      pend_bits  = '0;
      pend_cnt   = '0;
      grp_pos    = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function logic [7:0] sym_to_char(logic [4:0] s);
      logic [7:0] c;
      if (s < SYM_LETTERS) begin
        c = CHAR_UPPER_A + {3'd0, s};
      end else begin
        c = CHAR_TWO + {3'd0, s} - {3'd0, SYM_LETTERS};
      end
      return c;
    endfunction

    function void note_request(logic [7:0] b, logic l);
      logic [7:0]  chars [8];
      logic [11:0] acc;
      int          n;
      int          nb;
      n   = 0;
      acc = {(pend_bits & ((4'd1 << pend_cnt) - 4'd1)), b};
      nb  = pend_cnt + 8;
      while (nb >= 5) begin
        nb -= 5;
        chars[n] = sym_to_char(5'(acc >> nb));
        n++;
        grp_pos++;
      end
      acc = acc & ((12'd1 << nb) - 12'd1);
      if (l) begin
        if (nb > 0) begin
          chars[n] = sym_to_char(5'(acc << (5 - nb)));
          n++;
          grp_pos++;
        end
        while (grp_pos != 3'd0 && n < 8) begin
          chars[n] = CHAR_PAD;
          n++;
          grp_pos++;
        end
        pend_bits = '0;
        pend_cnt  = '0;
        grp_pos   = '0;
      end else begin
        pend_bits = acc[3:0];
        pend_cnt  = 3'(nb);
      end
      for (int i = 0; i < n; i++) begin
        expected_chars.push_back('{chars[i], (i == n - 1)});
      end
    endfunction

    function void check_char(logic [7:0] ch, logic eor);
      b32_char_t e;
      checked++;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRS) begin
          $display("ERROR: unexpected char %h last %b at %0t", ch, eor, $realtime);
        end
        return;
      end
      e = expected_chars.pop_front();
      if (e.ch !== ch || e.eor !== eor) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRS) begin
          $display("ERROR: char expected %h last %b, got %h last %b at %0t",
                   e.ch, e.eor, ch, eor, $realtime);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_char
  logic       out_tlast;

  char_scoreboard sb;
  bit  calm;
  bit  stall_go;
  bit  stall_done;
  int  hold_cnt;
  int  quiet;
  int  bytes_sent;
  int  msgs_sent;

  base32_stream_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // receiver: random stalls, one long hold-off
  initial begin
    out_tready = 1'b0;
    hold_cnt   = 0;
    stall_done = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_go && !stall_done) begin
        out_tready <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= HOLD_TICKS) stall_done = 1'b1;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 37);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_char(out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic l);
    if (!calm && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (l) msgs_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], (i == s.len() - 1));
    end
  endtask

  task automatic send_random_message(int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), (i == len - 1));
    end
  endtask

  initial begin
    int len;
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    calm       = 1'b0;
    stall_go   = 1'b0;
    quiet      = 0;
    bytes_sent = 0;
    msgs_sent  = 0;
    repeat (RESET_TICKS) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // all-zero and all-one single bytes, then every tail length
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_text("f");
    send_text("fo");
    send_text("foo");
    send_text("foob");
    send_text("fooba");
    send_text("foobar");

    stall_go = 1'b1;
    while (bytes_sent < RAND_BYTES) begin
      calm = (bytes_sent > 90 && bytes_sent < 130);
      if ($urandom_range(7) == 0) begin
        len = $urandom_range(20, 40);
      end else begin
        len = $urandom_range(1, 12);
      end
      send_random_message(len);
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);

    $display("Encoded %0d bytes in %0d messages, %0d characters checked.",
             bytes_sent, msgs_sent, sb.checked);
    $display("Output stalls, a long hold-off and a calm stretch were exercised.");
    if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d characters outstanding",
               sb.mismatches, sb.expected_chars.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> base32_stream_encoder.f
rtl/b32e_pkg.sv
rtl/b32e_front.sv
rtl/b32e_queue.sv
rtl/b32e_back.sv
rtl/base32_stream_encoder.sv
test/tb.sv
